// ===== rtl/uemseg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 emoji run segmenter package
// Shared constants, code point classes and the front-to-back item format.
// ----------------------------------------------------------------------------
package uemseg_pkg;

  localparam int MAX_UNITS_DEF = 65536;
  localparam int Q_DEPTH       = 2;

  localparam int CP_W = 21;

  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;
  localparam logic [5:0]  HI_TAG   = 6'b110110;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] VS16      = 21'h0FE0F;
  localparam logic [CP_W-1:0] VS15      = 21'h0FE0E;
  localparam logic [CP_W-1:0] ZWJ       = 21'h0200D;
  localparam logic [CP_W-1:0] TONE_LO   = 21'h1F3FB;
  localparam logic [CP_W-1:0] TONE_HI   = 21'h1F3FF;

  typedef struct packed {
    logic nul;
    logic emo;
    logic join_sel;
    logic tone;
  } cp_cls_t;

  // Up to two code points per unit, plus the end-of-text flag.
  typedef struct packed {
    logic    cp0_v;
    cp_cls_t cls0;
    logic    cp1_v;
    cp_cls_t cls1;
    logic    last;
  } ent_ctl_t;

  localparam int CTL_W = $bits(ent_ctl_t);

  function automatic logic in_rng(input logic [CP_W-1:0] c, input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic cp_cls_t cp_classify(input logic [CP_W-1:0] c);
    cp_cls_t r;
    r.nul  = (c == '0);
    r.emo  = in_rng(c, 21'h1F300, 21'h1F5FF) || in_rng(c, 21'h1F600, 21'h1F64F) ||
             in_rng(c, 21'h1F680, 21'h1F6FF) || in_rng(c, 21'h1F700, 21'h1F77F) ||
             in_rng(c, 21'h1F900, 21'h1F9FF) || in_rng(c, 21'h1FA70, 21'h1FAFF) ||
             in_rng(c, 21'h02600, 21'h027BF) || in_rng(c, 21'h1F1E6, 21'h1F1FF);
    r.join_sel = (c == VS16) || (c == VS15) || (c == ZWJ);
    r.tone = in_rng(c, TONE_LO, TONE_HI);
    return r;
  endfunction

endpackage

// ===== rtl/uemseg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter front end
// Pairs surrogates, tracks the unit offset and NUL, and classifies code points.
// ----------------------------------------------------------------------------
module uemseg_front #(
  parameter int MAX_UNITS = uemseg_pkg::MAX_UNITS_DEF,
  localparam int PW = $clog2(MAX_UNITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          code_unit,
  input  logic                 last_unit,
  output logic                 q_push,
  input  logic                 q_full,
  output uemseg_pkg::ent_ctl_t q_ctl,
  output logic [PW-1:0]        q_pos0,
  output logic [PW-1:0]        q_end_pos
);

  logic          lead_pending;
  logic [9:0]    lead_bits;
  logic [PW-1:0] pos;
  logic          nul_seen;

  logic          lead_pending_next;
  logic [9:0]    lead_bits_next;
  logic          processed;
  logic          is_hi;
  logic          is_lo;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] pos_p1;
  logic          a_v;
  logic          b_v;
  logic [uemseg_pkg::CP_W-1:0] cp_a;
  logic [uemseg_pkg::CP_W-1:0] cp_b;
  logic [uemseg_pkg::CP_W-1:0] ucp;
  logic [uemseg_pkg::CP_W-1:0] lead_cp;
  logic [uemseg_pkg::CP_W-1:0] pair_cp;
  uemseg_pkg::cp_cls_t cls_a;
  uemseg_pkg::cp_cls_t cls_b;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign is_hi = (code_unit >= uemseg_pkg::HI_FIRST) && (code_unit <= uemseg_pkg::HI_LAST);
  assign is_lo = (code_unit >= uemseg_pkg::LO_FIRST) && (code_unit <= uemseg_pkg::LO_LAST);

  assign processed = !nul_seen && (pos < PW'(MAX_UNITS));
  assign pos_m1    = pos - PW'(1);
  assign pos_p1    = pos + PW'(1);

  assign ucp     = {5'd0, code_unit};
  assign lead_cp = {5'd0, uemseg_pkg::HI_TAG, lead_bits};
  assign pair_cp = {1'b0, lead_bits, code_unit[9:0]} + uemseg_pkg::SUPP_BASE;

  always_comb begin
    a_v               = 1'b0;
    b_v               = 1'b0;
    cp_a              = ucp;
    cp_b              = ucp;
    q_pos0            = pos;
    lead_pending_next = lead_pending;
    lead_bits_next    = lead_bits;
    if (processed) begin
      if (lead_pending) begin
        a_v    = 1'b1;
        q_pos0 = pos_m1;
        if (is_lo) begin
          cp_a              = pair_cp;
          lead_pending_next = 1'b0;
        end else begin
          // The waiting high surrogate stands alone; the current unit follows it.
          cp_a = lead_cp;
          if (is_hi) begin
            lead_pending_next = 1'b1;
            lead_bits_next    = code_unit[9:0];
            b_v               = last_unit;
          end else begin
            lead_pending_next = 1'b0;
            b_v               = 1'b1;
          end
        end
      end else if (is_hi) begin
        lead_pending_next = 1'b1;
        lead_bits_next    = code_unit[9:0];
        a_v               = last_unit;
      end else begin
        a_v = 1'b1;
      end
    end else if (last_unit && lead_pending) begin
      a_v    = 1'b1;
      cp_a   = lead_cp;
      q_pos0 = pos_m1;
    end
  end

  assign cls_a = uemseg_pkg::cp_classify(cp_a);
  assign cls_b = uemseg_pkg::cp_classify(cp_b);

  assign q_ctl.cp0_v = a_v;
  assign q_ctl.cls0  = cls_a;
  assign q_ctl.cp1_v = b_v;
  assign q_ctl.cls1  = cls_b;
  assign q_ctl.last  = last_unit;
  assign q_end_pos   = processed ? pos_p1 : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_bits    <= '0;
      pos          <= '0;
      nul_seen     <= 1'b0;
    end else if (q_push) begin
      if (last_unit) begin
        lead_pending <= 1'b0;
        lead_bits    <= '0;
        pos          <= '0;
        nul_seen     <= 1'b0;
      end else begin
        lead_pending <= lead_pending_next;
        lead_bits    <= lead_bits_next;
        pos          <= q_end_pos;
        nul_seen     <= nul_seen || (a_v && cls_a.nul) || (b_v && cls_b.nul);
      end
    end
  end

endmodule

// ===== rtl/uemseg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter item queue
// Short FIFO between the front end and the run builder.
// ----------------------------------------------------------------------------
module uemseg_queue #(
  parameter int DATA_W = uemseg_pkg::CTL_W + 2 * $clog2(uemseg_pkg::MAX_UNITS_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  localparam int DEPTH = uemseg_pkg::Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/uemseg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter run builder
// Steps through the code points of each item, closes runs and emits results.
// ----------------------------------------------------------------------------
module uemseg_back #(
  parameter int MAX_UNITS = uemseg_pkg::MAX_UNITS_DEF,
  localparam int PW = $clog2(MAX_UNITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  uemseg_pkg::ent_ctl_t q_ctl,
  input  logic [PW-1:0]        q_pos0,
  input  logic [PW-1:0]        q_end_pos,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 run_valid,
  output logic [15:0]          run_start,
  output logic [16:0]          run_length,
  output logic                 run_is_emoji,
  output logic                 final_result,
  output logic                 text_has_emoji,
  output logic                 text_emoji_only
);

  localparam logic [1:0] PH_CP0 = 2'd0;
  localparam logic [1:0] PH_CP1 = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  logic [1:0]    phase;
  logic          run_open;
  logic          open_run_emoji;
  logic [PW-1:0] open_run_start;
  logic          seen_emoji;
  logic          seen_emoji_base;
  logic          saw_non_emoji;

  logic          run_open_next;
  logic          open_run_emoji_next;
  logic [PW-1:0] open_run_start_next;
  logic          seen_emoji_next;
  logic          seen_emoji_base_next;
  logic          saw_non_emoji_next;

  logic          do_cp;
  logic          do_fin;
  logic          more;
  logic [1:0]    phase_after;
  logic          step;
  logic          emit;
  logic          stays;
  logic          is_comp;
  uemseg_pkg::cp_cls_t sel_cls;
  logic [PW-1:0] sel_pos;

  logic          e_valid;
  logic [PW-1:0] e_start;
  logic [PW-1:0] e_end;
  logic          e_emoji;
  logic          e_final;
  logic          e_has;
  logic          e_only;

  assign step = q_valid && (!out_valid || out_ready);

  always_comb begin
    case (phase)
      PH_CP0: begin
        do_cp       = q_ctl.cp0_v;
        do_fin      = !q_ctl.cp0_v && q_ctl.last;
        more        = q_ctl.cp0_v && (q_ctl.cp1_v || q_ctl.last);
        phase_after = q_ctl.cp1_v ? PH_CP1 : PH_FIN;
      end
      PH_CP1: begin
        do_cp       = 1'b1;
        do_fin      = 1'b0;
        more        = q_ctl.last;
        phase_after = PH_FIN;
      end
      PH_FIN: begin
        do_cp       = 1'b0;
        do_fin      = 1'b1;
        more        = 1'b0;
        phase_after = PH_CP0;
      end
      default: begin
        do_cp       = 1'b0;
        do_fin      = 1'b0;
        more        = 1'b0;
        phase_after = PH_CP0;
      end
    endcase
  end

  assign sel_cls = (phase == PH_CP1) ? q_ctl.cls1 : q_ctl.cls0;
  assign sel_pos = (phase == PH_CP1) ? (q_pos0 + PW'(1)) : q_pos0;
  assign is_comp = sel_cls.emo || sel_cls.join_sel || sel_cls.tone;
  assign stays   = open_run_emoji ? is_comp : !sel_cls.emo;

  always_comb begin
    run_open_next        = run_open;
    open_run_emoji_next  = open_run_emoji;
    open_run_start_next  = open_run_start;
    seen_emoji_next      = seen_emoji;
    seen_emoji_base_next = seen_emoji_base;
    saw_non_emoji_next   = saw_non_emoji;
    emit    = 1'b0;
    e_valid = 1'b1;
    e_start = open_run_start;
    e_end   = sel_pos;
    e_emoji = open_run_emoji;
    e_final = 1'b0;
    e_has   = 1'b0;
    e_only  = 1'b0;
    if (do_cp) begin
      if (sel_cls.nul) begin
        emit          = run_open;
        run_open_next = 1'b0;
      end else begin
        seen_emoji_next = seen_emoji || sel_cls.emo;
        // Selectors, joiners and tones count neither as emoji base nor as text.
        if (!sel_cls.join_sel && !sel_cls.tone) begin
          seen_emoji_base_next = seen_emoji_base || sel_cls.emo;
          saw_non_emoji_next   = saw_non_emoji || !sel_cls.emo;
        end
        emit = run_open && !stays;
        if (!run_open || !stays) begin
          run_open_next       = 1'b1;
          open_run_emoji_next = sel_cls.emo;
          open_run_start_next = sel_pos;
        end
      end
    end else if (do_fin) begin
      // Close the open run as final, or send an empty final marker.
      emit    = 1'b1;
      e_valid = run_open;
      e_start = run_open ? open_run_start : '0;
      e_end   = run_open ? q_end_pos : '0;
      e_emoji = run_open && open_run_emoji;
      e_final = 1'b1;
      e_has   = seen_emoji;
      e_only  = seen_emoji_base && !saw_non_emoji;
      run_open_next        = 1'b0;
      open_run_emoji_next  = 1'b0;
      open_run_start_next  = '0;
      seen_emoji_next      = 1'b0;
      seen_emoji_base_next = 1'b0;
      saw_non_emoji_next   = 1'b0;
    end
  end

  assign q_pop = step && !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CP0;
      run_open        <= 1'b0;
      open_run_emoji  <= 1'b0;
      open_run_start  <= '0;
      seen_emoji      <= 1'b0;
      seen_emoji_base <= 1'b0;
      saw_non_emoji   <= 1'b0;
    end else if (step) begin
      phase           <= more ? phase_after : PH_CP0;
      run_open        <= run_open_next;
      open_run_emoji  <= open_run_emoji_next;
      open_run_start  <= open_run_start_next;
      seen_emoji      <= seen_emoji_next;
      seen_emoji_base <= seen_emoji_base_next;
      saw_non_emoji   <= saw_non_emoji_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      run_valid       <= e_valid;
      run_start       <= 16'(e_start);
      run_length      <= 17'(e_end - e_start);
      run_is_emoji    <= e_emoji;
      final_result    <= e_final;
      text_has_emoji  <= e_has;
      text_emoji_only <= e_only;
    end
  end

`ifndef SYNTHESIS
  a_marker_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_valid |-> final_result && (run_length == '0) && !run_is_emoji)
    else $error("empty marker without final flag");

  a_flags_only_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_result |-> !text_has_emoji && !text_emoji_only)
    else $error("text flags on a non-final result");

  a_only_implies_has: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_emoji_only |-> text_has_emoji)
    else $error("emoji-only without has-emoji");

  a_mid_item_held: assert property (@(posedge clk) disable iff (rst)
    phase != PH_CP0 |-> q_valid)
    else $error("item left the queue before all its steps were done");
`endif

endmodule

// ===== rtl/utf16_emoji_run_segmenter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 emoji run segmenter
// Decodes UTF-16 code units and splits the text into emoji and text runs.
// ----------------------------------------------------------------------------
// A result from an item's first run builder step reaches the output register once the item
//   has passed through the queue; later steps of the same item follow it in turn.
// Throughput: one code unit per cycle unless the queue is full; the run builder takes a step
//   for each code point of an item and a final step for a last unit, so the queue can fill.
// A two-item queue lets input keep flowing while the output register is stalled.
// Reset: synchronous, active high; clears all decode and run state, no clearing pass.
module utf16_emoji_run_segmenter_top #(
  parameter int MAX_UNITS = uemseg_pkg::MAX_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        run_valid,
  output logic [15:0] run_start,
  output logic [16:0] run_length,
  output logic        run_is_emoji,
  output logic        final_result,
  output logic        text_has_emoji,
  output logic        text_emoji_only
);

  localparam int PW     = $clog2(MAX_UNITS + 1);
  localparam int DATA_W = uemseg_pkg::CTL_W + 2 * PW;

  logic                 f_push;
  logic                 q_full;
  uemseg_pkg::ent_ctl_t f_ctl;
  logic [PW-1:0]        f_pos0;
  logic [PW-1:0]        f_end_pos;
  logic                 q_valid;
  logic                 q_pop;
  logic [DATA_W-1:0]    q_data;
  uemseg_pkg::ent_ctl_t b_ctl;
  logic [PW-1:0]        b_pos0;
  logic [PW-1:0]        b_end_pos;

  uemseg_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_push    (f_push),
    .q_full    (q_full),
    .q_ctl     (f_ctl),
    .q_pos0    (f_pos0),
    .q_end_pos (f_end_pos)
  );

  uemseg_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  ({f_ctl, f_pos0, f_end_pos}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign {b_ctl, b_pos0, b_end_pos} = q_data;

  uemseg_back #(
    .MAX_UNITS(MAX_UNITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ctl           (b_ctl),
    .q_pos0          (b_pos0),
    .q_end_pos       (b_end_pos),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .run_valid       (run_valid),
    .run_start       (run_start),
    .run_length      (run_length),
    .run_is_emoji    (run_is_emoji),
    .final_result    (final_result),
    .text_has_emoji  (text_has_emoji),
    .text_emoji_only (text_emoji_only)
  );

endmodule
